@@ hw/rtl/fdly_pkg.sv @@
// Shared constants for the feedback delay echo unit.
// No dependencies; used by the top level and its checker.
package fdly_pkg;

  // word fields
  localparam int DATA_W = 24;
  localparam int CH_W   = 3;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int DLY_W      = 16;
  localparam int GAIN_W     = 17;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLED  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIX      = 2'd3;

  localparam logic              RST_ENABLED  = 1'b1;
  localparam logic [DLY_W-1:0]  RST_DELAY    = 16'd48000;
  localparam logic [GAIN_W-1:0] RST_FEEDBACK = 17'd19661;
  localparam logic [GAIN_W-1:0] RST_MIX      = 17'd32768;

  // Q1.16 unity gain
  localparam logic [GAIN_W-1:0] UNITY = 17'd65536;

  // default sizing
  localparam int DEPTH_DEF    = 65536;
  localparam int CHANNELS_DEF = 2;

  // words in flight between input and output
  localparam int OUT_SLOTS = 2;

endpackage

@@ hw/rtl/fdly_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read.
// Read during a write to the same address returns the old data.
module fdly_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/feedback_delay_echo_unit.sv @@
// Feedback delay echo: top level.
// Uses fdly_pkg for constants and fdly_ram for the delay store.

// Multi-channel feedback echo over a single delay RAM holding CHANNELS x DEPTH
// 24-bit entries. No new word is taken while the last is still in stage 1;
// a result passes stage 1, stage 2 and the output buffer. The spacing comes
// from the read-modify-write of the delay RAM (read issued at accept, multiply
// on the read data, write back of the new entry), with the last write forwarded
// to the next read. After reset a clearing pass zeroes every RAM entry, during
// which in_stall is held high; configuration writes are taken at any time with
// cfg_ready tied high, but should only be issued while no word is in flight. A
// two-word output buffer lets input flow on while out_stall is high, until full.
module feedback_delay_echo_unit #(
  parameter int DEPTH    = fdly_pkg::DEPTH_DEF,
  parameter int CHANNELS = fdly_pkg::CHANNELS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input words
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [fdly_pkg::DATA_W-1:0]    in_sample_in,
  input  logic        [fdly_pkg::CH_W-1:0]      in_channel,
  // result words
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [fdly_pkg::DATA_W-1:0]    out_sample_out,
  // configuration writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic        [fdly_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [fdly_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int DATA_W    = fdly_pkg::DATA_W;
  localparam int CH_W      = fdly_pkg::CH_W;
  localparam int GAIN_W    = fdly_pkg::GAIN_W;
  localparam int POS_W     = $clog2(DEPTH);
  localparam int MEM_DEPTH = CHANNELS * DEPTH;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int PW        = AW + CH_W;
  localparam int DW        = (POS_W > fdly_pkg::DLY_W) ? POS_W : fdly_pkg::DLY_W;
  localparam int PROD_W    = DATA_W + GAIN_W + 1;
  localparam int SLOT_W    = $clog2(fdly_pkg::OUT_SLOTS);
  localparam int CNT_W     = $clog2(fdly_pkg::OUT_SLOTS + 1);

  typedef logic signed [DATA_W-1:0] smp_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  localparam prod_t SMP_MAX = prod_t'((1 << (DATA_W - 1)) - 1);
  localparam prod_t SMP_MIN = -prod_t'(1 << (DATA_W - 1));
  localparam prod_t RND_HALF = prod_t'(1 << 15);

  function automatic smp_t sat_smp(input prod_t v);
    smp_t res;
    if (v > SMP_MAX) begin
      res = smp_t'(SMP_MAX);
    end else if (v < SMP_MIN) begin
      res = smp_t'(SMP_MIN);
    end else begin
      res = smp_t'(v);
    end
    return res;
  endfunction

  // round Q16 fraction bits away, half up (floor of x + 0.5)
  function automatic prod_t rnd_q16(input prod_t v);
    prod_t t;
    t = v + RND_HALF;
    return t >>> 16;
  endfunction

  // ---------------------------------------------------------------- config
  logic                           en_r;
  logic [fdly_pkg::DLY_W-1:0]     dly_r;
  logic [GAIN_W-1:0]              fb_r;
  logic [GAIN_W-1:0]              mix_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r  <= fdly_pkg::RST_ENABLED;
      dly_r <= fdly_pkg::RST_DELAY;
      fb_r  <= fdly_pkg::RST_FEEDBACK;
      mix_r <= fdly_pkg::RST_MIX;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fdly_pkg::REG_ENABLED:  en_r  <= cfg_data[0];
        fdly_pkg::REG_DELAY:    dly_r <= cfg_data[fdly_pkg::DLY_W-1:0];
        fdly_pkg::REG_FEEDBACK: fb_r  <= cfg_data[GAIN_W-1:0];
        fdly_pkg::REG_MIX:      mix_r <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  logic [GAIN_W-1:0] fb_g;
  logic [GAIN_W-1:0] wet_g;
  logic [GAIN_W-1:0] dry_g;

  assign fb_g  = (fb_r > fdly_pkg::UNITY) ? fdly_pkg::UNITY : fb_r;
  assign wet_g = (mix_r > fdly_pkg::UNITY) ? fdly_pkg::UNITY : mix_r;
  assign dry_g = fdly_pkg::UNITY - wet_g;

  // ---------------------------------------------------------------- clearing
  logic          clr_r;
  logic [AW-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == AW'(MEM_DEPTH - 1)) begin
        clr_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- accept / positions
  logic              s1_v_r;
  logic              s2_v_r;
  logic [CNT_W-1:0]  fifo_cnt_r;
  logic              accept;

  assign in_stall = clr_r || s1_v_r ||
                    ((CNT_W'(s2_v_r) + fifo_cnt_r) >= CNT_W'(fdly_pkg::OUT_SLOTS));
  assign accept   = in_valid && !in_stall;

  logic [POS_W-1:0] wp_r;
  logic [POS_W-1:0] rp_r;
  logic [POS_W-1:0] wp_inc;
  logic [DW-1:0]    dly_cl;
  logic [POS_W-1:0] dly_pos;
  logic [POS_W-1:0] rp_calc;
  logic [POS_W-1:0] w_pos;
  logic [POS_W-1:0] r_pos;
  logic             adv;
  logic             act;
  logic [PW-1:0]    ch_base;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;

  assign adv    = en_r && (in_channel == '0);
  assign act    = en_r && ({1'b0, in_channel} < (CH_W + 1)'(CHANNELS));
  assign wp_inc = (wp_r == POS_W'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
  assign dly_cl = (DW'(dly_r) > DW'(DEPTH - 1)) ? DW'(DEPTH - 1) : DW'(dly_r);
  assign dly_pos = dly_cl[POS_W-1:0];
  assign rp_calc = (wp_inc >= dly_pos) ? (wp_inc - dly_pos)
                 : POS_W'((POS_W + 1)'(wp_inc) + (POS_W + 1)'(DEPTH) - (POS_W + 1)'(dly_pos));
  assign w_pos   = adv ? wp_inc : wp_r;
  assign r_pos   = adv ? rp_calc : rp_r;
  assign ch_base = PW'(in_channel) * PW'(DEPTH);
  assign rd_addr = AW'(ch_base + PW'(r_pos));
  assign wr_addr = AW'(ch_base + PW'(w_pos));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else if (accept && adv) begin
      wp_r <= wp_inc;
      rp_r <= rp_calc;
    end
  end

  // ---------------------------------------------------------------- stage 1: RAM read data
  smp_t          s1_x_r;
  logic          s1_act_r;
  logic          s1_self_r;
  logic [AW-1:0] s1_raddr_r;
  logic [AW-1:0] s1_waddr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x_r     <= in_sample_in;
      s1_act_r   <= act;
      s1_self_r  <= (r_pos == w_pos);
      s1_raddr_r <= rd_addr;
      s1_waddr_r <= wr_addr;
    end
  end

  // last RAM write, forwarded to a read issued in the same cycle
  logic          wl_v_r;
  logic [AW-1:0] wl_addr_r;
  smp_t          wl_data_r;

  logic [DATA_W-1:0] ram_rdata;
  smp_t              delayed;

  // zero delay reads back the word being stored
  assign delayed = s1_self_r ? s1_x_r
                 : (wl_v_r && (wl_addr_r == s1_raddr_r)) ? wl_data_r
                 : smp_t'(ram_rdata);

  // ---------------------------------------------------------------- stage 2: products
  smp_t          s2_x_r;
  logic          s2_act_r;
  logic [AW-1:0] s2_waddr_r;
  prod_t         s2_pfb_r;
  prod_t         s2_pdry_r;
  prod_t         s2_pwet_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      s2_x_r     <= s1_x_r;
      s2_act_r   <= s1_act_r;
      s2_waddr_r <= s1_waddr_r;
      s2_pfb_r   <= delayed * $signed({1'b0, fb_g});
      s2_pdry_r  <= s1_x_r * $signed({1'b0, dry_g});
      s2_pwet_r  <= delayed * $signed({1'b0, wet_g});
    end
  end

  smp_t  st_val;
  smp_t  y_val;
  prod_t fb_rnd;
  prod_t mix_rnd;

  assign fb_rnd  = rnd_q16(s2_pfb_r);
  assign mix_rnd = rnd_q16(s2_pdry_r + s2_pwet_r);
  assign st_val  = sat_smp(prod_t'(s2_x_r) + fb_rnd);
  assign y_val   = s2_act_r ? sat_smp(mix_rnd) : s2_x_r;

  logic wb_en;
  assign wb_en = s2_v_r && s2_act_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_v_r <= 1'b0;
    end else if (wb_en) begin
      wl_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_en) begin
      wl_addr_r <= s2_waddr_r;
      wl_data_r <= st_val;
    end
  end

  // ---------------------------------------------------------------- delay RAM
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;

  assign ram_we    = clr_r || wb_en;
  assign ram_waddr = clr_r ? clr_cnt_r : s2_waddr_r;
  assign ram_wdata = clr_r ? '0 : DATA_W'(st_val);

  fdly_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------- output buffer
  smp_t              fifo_q_r [fdly_pkg::OUT_SLOTS];
  logic [SLOT_W-1:0] fifo_wp_r;
  logic [SLOT_W-1:0] fifo_rp_r;
  logic [CNT_W-1:0]  fifo_cnt_nxt;
  logic              pop;

  assign out_valid      = (fifo_cnt_r != '0);
  assign out_sample_out = fifo_q_r[fifo_rp_r];
  assign pop            = out_valid && !out_stall;
  assign fifo_cnt_nxt   = fifo_cnt_r + CNT_W'(s2_v_r) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fifo_cnt_r <= '0;
      fifo_wp_r  <= '0;
      fifo_rp_r  <= '0;
    end else begin
      fifo_cnt_r <= fifo_cnt_nxt;
      if (s2_v_r) begin
        fifo_wp_r <= fifo_wp_r + 1'b1;
      end
      if (pop) begin
        fifo_rp_r <= fifo_rp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v_r) begin
      fifo_q_r[fifo_wp_r] <= y_val;
    end
  end

endmodule

@@ hw/rtl/fdly_checker.sv @@
// Port-level checker for the feedback delay echo unit, bound to the top level.
// Uses fdly_pkg for widths and the output buffer size.
module fdly_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_stall,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic signed [fdly_pkg::DATA_W-1:0]    out_sample_out
);

  logic [2:0] outst_r;
  logic [2:0] outst_nxt;
  logic       in_acc;
  logic       out_acc;

  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign outst_nxt = outst_r + 3'(in_acc) - 3'(out_acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outst_r <= '0;
    end else begin
      outst_r <= outst_nxt;
    end
  end

  // clearing pass blocks input right after reset
  a_stall_after_rst: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input not stalled after reset");

  // read-modify-write spacing: words are never accepted back to back
  a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("words accepted on consecutive cycles");

  // a result only for a word that was taken in
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> outst_r != 3'd0)
    else $error("result word without pending input");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    outst_r <= 3'(fdly_pkg::OUT_SLOTS))
    else $error("too many words in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample_out))
    else $error("stalled result word changed");

endmodule

bind feedback_delay_echo_unit fdly_checker u_fdly_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_sample_out (out_sample_out)
);
